// File: design/rgb_eight_neighbour_blur_macros.svh
// Assertion macros for the eight-neighbour blur checker.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef RGB_EIGHT_NEIGHBOUR_BLUR_MACROS_SVH
`define RGB_EIGHT_NEIGHBOUR_BLUR_MACROS_SVH

// General property, sampled on the rising clock edge and switched off in reset.
`define RGBB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal must hold while its request is stalled.
`define RGBB_ASSERT_STALL_STABLE(name, vld, rdy, sig, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// File: design/rgbb_pkg.sv
// Shared types, constants and the blur function for the eight-neighbour blur.
// Depends on nothing; imported by the front end, queue, back end and top-level module.
package rgbb_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int unsigned MAX_HEIGHT    = 4096;

    localparam int unsigned FW_BITS      = 11;
    localparam int unsigned FH_BITS      = 13;
    localparam int unsigned ROW_BITS     = 12;
    localparam int unsigned CFG_BITS     = 13;
    localparam int unsigned CFG_IDX_BITS = 1;

    localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_BITS-1:0] FH_RESET = 13'd768;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
    localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Indexed [row][column]; row 0 is the oldest line, column 2 the newest pixel.
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic    emit_main;
        logic    use_blur;
        logic    emit_edge;
        logic    frame_end;
        window_t win;
    } blur_op_t;

    // Sum of each neighbour divided by eight; the centre is left out.
    function automatic pixel_t blur_window(window_t w);
        pixel_t res;
        res = '0;
        for (int y = 0; y < 3; y++)
        begin
            for (int x = 0; x < 3; x++)
            begin
                if (!(y == 1 && x == 1))
                begin
                    res.red   = res.red   + {3'b000, w[y][x].red[7:3]};
                    res.green = res.green + {3'b000, w[y][x].green[7:3]};
                    res.blue  = res.blue  + {3'b000, w[y][x].blue[7:3]};
                end
            end
        end
        return res;
    endfunction

endpackage

// File: design/rgbb_front.sv
// Front end: takes requests, keeps the frame position, the line buffers and the window,
// and hands one blur operation per useful request to the queue. Depends on rgbb_pkg.
module rgbb_front
    import rgbb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  logic                    s_tuser,
    input  logic [QCNT_BITS-1:0]    q_count,
    output logic                    op_push,
    output blur_op_t                op
);

    localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W = (FW_BITS > WW) ? FW_BITS : WW;

    typedef struct packed {
        logic          drain;
        logic [AW-1:0] addr;
        pixel_t        pix;
        logic          fwd;
        logic          emit_main;
        logic          use_blur;
        logic          emit_edge;
        logic          last;
    } stage_t;

    logic [FW_BITS-1:0]  frame_width_reg;
    logic [FH_BITS-1:0]  frame_height_reg;
    logic [AW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [AW-1:0]       drain_idx_reg, drain_idx_next;
    logic                draining_reg, draining_next;
    logic                s1_valid_reg;
    stage_t              s1_reg, s1_next;

    pixel_t  older_mem [MAX_WIDTH];
    pixel_t  newer_mem [MAX_WIDTH];
    pixel_t  rd_older_reg, rd_newer_reg;
    pixel_t  fw_older_reg, fw_newer_reg;
    window_t window_reg;

    logic [CMP_W-1:0]    fw_ext;
    logic [CMP_W-1:0]    w_last;
    logic [ROW_BITS-1:0] h_last;
    logic                accept, take_pixel, take_drain;
    logic [AW-1:0]       rd_addr;
    logic                row_end, drain_last;
    pixel_t              pix_in;
    pixel_t              eff_older, eff_newer;
    window_t             nwin;
    logic                s1_pixel;

    // Effective frame size, with zero read as one and oversize clamped.
    assign fw_ext = CMP_W'(frame_width_reg);

    always_comb
    begin
        if (fw_ext == '0)
            w_last = '0;
        else if (fw_ext > CMP_W'(MAX_WIDTH))
            w_last = CMP_W'(MAX_WIDTH - 1);
        else
            w_last = fw_ext - CMP_W'(1);
    end

    always_comb
    begin
        if (frame_height_reg == '0)
            h_last = '0;
        else if (frame_height_reg > FH_BITS'(MAX_HEIGHT))
            h_last = ROW_BITS'(MAX_HEIGHT - 1);
        else
            h_last = ROW_BITS'(frame_height_reg - FH_BITS'(1));
    end

    // Room is kept in the queue for the operation in flight and the one being taken.
    assign s_tready = ({1'b0, q_count} + (QCNT_BITS + 1)'(s1_valid_reg))
                      < (QCNT_BITS + 1)'(QDEPTH);
    assign accept     = s_tvalid && s_tready;
    assign take_pixel = accept && (s_tuser == CMD_PIXEL) && !draining_reg;
    assign take_drain = accept && (s_tuser == CMD_DRAIN) && draining_reg;

    assign pix_in.red   = s_tdata[7:0];
    assign pix_in.green = s_tdata[15:8];
    assign pix_in.blue  = s_tdata[23:16];

    assign rd_addr    = take_drain ? drain_idx_reg : col_reg;
    assign row_end    = CMP_W'(col_reg) >= w_last;
    assign drain_last = CMP_W'(drain_idx_reg) >= w_last;

    always_comb
    begin
        s1_next.drain     = take_drain;
        s1_next.addr      = rd_addr;
        s1_next.pix       = pix_in;
        // The previous pixel writes this address only after our read has been issued.
        s1_next.fwd       = s1_valid_reg && !s1_reg.drain && (s1_reg.addr == rd_addr);
        s1_next.emit_main = (row_reg != '0) && (col_reg != '0);
        s1_next.use_blur  = (row_reg >= ROW_BITS'(2)) && (CMP_W'(col_reg) >= CMP_W'(2))
                            && (row_reg <= h_last) && (CMP_W'(col_reg) <= w_last);
        s1_next.emit_edge = (row_reg != '0) && row_end;
        s1_next.last      = drain_last;
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        drain_idx_next = drain_idx_reg;
        draining_next  = draining_reg;
        if (take_pixel)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (row_reg >= h_last)
                begin
                    row_next       = '0;
                    draining_next  = 1'b1;
                    drain_idx_next = '0;
                end
                else
                begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (take_drain)
        begin
            if (drain_last)
            begin
                draining_next  = 1'b0;
                drain_idx_next = '0;
            end
            else
            begin
                drain_idx_next = drain_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            drain_idx_reg    <= '0;
            draining_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            drain_idx_reg <= drain_idx_next;
            draining_reg  <= draining_next;
            s1_valid_reg  <= take_pixel || take_drain;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_pixel || take_drain)
        begin
            s1_reg       <= s1_next;
            rd_older_reg <= older_mem[rd_addr];
            rd_newer_reg <= newer_mem[rd_addr];
        end
    end

    // Second stage: memory data arrives, the window shifts and the lines are updated.
    assign s1_pixel  = s1_valid_reg && !s1_reg.drain;
    assign eff_older = s1_reg.fwd ? fw_older_reg : rd_older_reg;
    assign eff_newer = s1_reg.fwd ? fw_newer_reg : rd_newer_reg;

    always_comb
    begin
        for (int y = 0; y < 3; y++)
        begin
            nwin[y][0] = window_reg[y][1];
            nwin[y][1] = window_reg[y][2];
        end
        nwin[0][2] = eff_older;
        nwin[1][2] = eff_newer;
        nwin[2][2] = s1_reg.pix;
    end

    always_ff @(posedge clk)
    begin
        if (s1_pixel)
        begin
            older_mem[s1_reg.addr] <= eff_newer;
            newer_mem[s1_reg.addr] <= s1_reg.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_pixel)
        begin
            fw_older_reg <= eff_newer;
            fw_newer_reg <= s1_reg.pix;
            window_reg   <= nwin;
        end
    end

    always_comb
    begin
        op.emit_main = s1_reg.drain || s1_reg.emit_main;
        op.use_blur  = !s1_reg.drain && s1_reg.use_blur;
        op.emit_edge = !s1_reg.drain && s1_reg.emit_edge;
        op.frame_end = s1_reg.drain && s1_reg.last;
        op.win       = nwin;
        // A drained pixel of the last row leaves as a plain centre value.
        if (s1_reg.drain)
            op.win[1][1] = eff_newer;
    end

    assign op_push = s1_valid_reg && (s1_reg.drain || s1_reg.emit_main || s1_reg.emit_edge);

endmodule

// File: design/rgbb_queue.sv
// Short queue of blur operations between the front end and the back end.
// Depends on rgbb_pkg.
module rgbb_queue
    import rgbb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  blur_op_t             push_op,
    input  logic                 pop,
    output blur_op_t             head,
    output logic [QCNT_BITS-1:0] count
);

    blur_op_t               ent_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_BITS'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_BITS'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_op;
    end

    assign head  = ent_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: design/rgbb_back.sv
// Back end: turns each queued operation into one or two output pixels, blurring
// interior pixels, through a single output register. Depends on rgbb_pkg.
module rgbb_back
    import rgbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  blur_op_t    head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic   out_valid_reg, out_valid_next;
    logic   main_done_reg, main_done_next;
    pixel_t out_pix_reg;
    logic   out_last_reg;

    logic   sel_edge;
    logic   load;
    pixel_t res_pix;
    logic   res_last;

    // Once the main pixel of an operation has gone, its row-end pixel follows.
    assign sel_edge = !head.emit_main || main_done_reg;

    always_comb
    begin
        if (sel_edge)
            res_pix = head.win[1][2];
        else if (head.use_blur)
            res_pix = blur_window(head.win);
        else
            res_pix = head.win[1][1];
    end

    assign res_last = !sel_edge && head.frame_end;
    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign pop      = load && (sel_edge || !head.emit_edge);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        main_done_next = main_done_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            main_done_next = !pop;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            main_done_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            main_done_reg <= main_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_pix_reg  <= res_pix;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};
    assign m_tlast  = out_last_reg;

endmodule

// File: design/rgb_eight_neighbour_blur.sv
// Eight-neighbour RGB blur over a raster stream. An accepted request passes the
// front-end stage and queue to the output register; one request is taken every cycle.
// The single output register gives one pixel per cycle unless stalled; the four-entry
// operation queue absorbs the extra pixel at each row end and may hold off the input.
// Reset (asynchronous, active low) clears position, drain and queue state and sets the
// frame size to 1024 x 768; the line buffers are not cleared and need no clearing pass.
module rgb_eight_neighbour_blur
    import rgbb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // red_in, green_in, blue_in
    input  logic                    s_tuser,   // cmd
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // red_out, green_out, blue_out
    output logic                    m_tlast
);

    logic                 op_push;
    blur_op_t             op;
    blur_op_t             head;
    logic [QCNT_BITS-1:0] q_count;
    logic                 pop;

    rgbb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .op_push   (op_push),
        .op        (op)
    );

    rgbb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (op_push),
        .push_op (op),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    rgbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_count != '0),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: design/rgbb_checker.sv
// Port-level checks for the eight-neighbour blur, bound to the top level.
// Depends on rgb_eight_neighbour_blur_macros.svh and the top-level module.
`include "rgb_eight_neighbour_blur_macros.svh"

module rgbb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    `RGBB_ASSERT(a_out_valid_held, (m_tvalid && !m_tready) |=> m_tvalid, "output request dropped while stalled")
    `RGBB_ASSERT_STALL_STABLE(a_out_data_held, m_tvalid, m_tready, {m_tdata, m_tlast}, "output payload changed while stalled")
    // A fresh output run can only start from a request already taken and queued.
    `RGBB_ASSERT(a_out_start_latency, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3), "output started without a matching request")
    // With the output register empty the queue is nearly empty, so input must be open.
    `RGBB_ASSERT(a_ready_when_idle, !m_tvalid |-> s_tready, "input held off while the output side is empty")

endmodule

bind rgb_eight_neighbour_blur rgbb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
